### src/csvt_pkg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared types and constants for the CSV field tokenizer and its checker.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  // Parser mode; the unused code behaves as unquoted.
  typedef enum logic [1:0] {
    MODE_UNQUOTED = 2'd0,
    MODE_QUOTED   = 2'd1,
    MODE_PENDING  = 2'd2
  } mode_e;

  // Input beat function, carried in tuser.
  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_EOL  = 1'b1
  } func_e;

  // Result kind, carried in tuser.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_END  = 2'd2,
    KIND_QUOTE_ERR = 2'd3
  } kind_e;

endpackage

### src/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a CSV line, one byte per beat, into field data and field markers.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat per line byte (tuser = 0, byte in tdata)
//   or an end-of-line marker (tuser = 1, tdata ignored). The master stream
//   gives at most one beat per input beat: a field data byte, a field end,
//   a last-field-of-line end or an unterminated quote error, kind in tuser.
//   The delimiter register is loaded over the cfg channel, which is always
//   ready; write it only while no line is in flight.
//   Throughput is one byte per cycle while the receiver takes results. A
//   result passes from its accepted input beat through the input register,
//   the single mode update and then the output register before it leaves.
//   Reset clears both stages, returns the parser to unquoted mode and the
//   delimiter to a comma. When the receiver stalls, the output register
//   holds its beat and the input register still fills, so one more beat is
//   taken before tready falls.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,     // delimiter_char
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i, // [7:0] character
  input  logic       s_axis_tuser_i, // [0] func
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o, // [7:0] data_byte
  output logic [1:0] m_axis_tuser_o  // [1:0] kind
);

  logic [7:0]           delim_q;
  logic                 in_valid_q;
  logic [7:0]           in_char_q;
  csvt_pkg::func_e      in_func_q;
  csvt_pkg::mode_e      mode_q, mode_d;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  csvt_pkg::kind_e      out_kind_q;

  logic                 out_free;
  logic                 advance;
  logic                 res_valid;
  csvt_pkg::kind_e      res_kind;
  logic [7:0]           res_byte;

  assign cfg_ready_o = 1'b1;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csvt_pkg::DELIM_RESET;
    end else if (cfg_valid_i) begin
      delim_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_func_q <= csvt_pkg::func_e'(s_axis_tuser_i);
    end
  end

  // Mode update and result for the beat held in the input register.
  always_comb begin
    logic is_quote;
    logic is_delim;
    is_quote  = (in_char_q == csvt_pkg::QUOTE_BYTE);
    is_delim  = (in_char_q == delim_q);
    mode_d    = mode_q;
    res_valid = 1'b1;
    res_kind  = csvt_pkg::KIND_DATA;
    res_byte  = in_char_q;
    if (in_func_q == csvt_pkg::FUNC_EOL) begin
      mode_d   = csvt_pkg::MODE_UNQUOTED;
      res_byte = 8'd0;
      res_kind = (mode_q == csvt_pkg::MODE_QUOTED) ? csvt_pkg::KIND_QUOTE_ERR
                                                   : csvt_pkg::KIND_LINE_END;
    end else begin
      case (mode_q)
        csvt_pkg::MODE_QUOTED: begin
          if (is_quote) begin
            mode_d    = csvt_pkg::MODE_PENDING;
            res_valid = 1'b0;
          end
        end
        default: begin
          // A doubled quote inside quotes gives one literal quote; any other
          // byte after a pending quote is handled as outside quotes.
          if (is_quote && mode_q == csvt_pkg::MODE_PENDING) begin
            mode_d = csvt_pkg::MODE_QUOTED;
          end else if (is_quote) begin
            mode_d    = csvt_pkg::MODE_QUOTED;
            res_valid = 1'b0;
          end else begin
            mode_d = csvt_pkg::MODE_UNQUOTED;
            if (is_delim) begin
              res_kind = csvt_pkg::KIND_FIELD_END;
              res_byte = 8'd0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= csvt_pkg::MODE_UNQUOTED;
    end else if (advance) begin
      mode_q <= mode_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

### src/csvt_checker.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer checker
// Port-level assertions on the CSV field tokenizer, bound to every instance of it.
// ----------------------------------------------------------------------------
module csvt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  // Marker and error beats carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != csvt_pkg::KIND_DATA |->
      m_axis_tdata_o == 8'd0)
    else $error("non-data beat with a non-zero byte");

  // The input side only backs up behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a stalled output");

  // Nothing is offered straight out of reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result beat offered out of reset");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### dv/csv_field_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Feeds CSV lines, end-of-line beats and noise through the tokenizer under
// several delimiters and idling profiles, and checks every result beat
// against a behavioural parser kept in step with the accepted input beats.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb;

  localparam int IDLE_LIMIT     = 5000;
  localparam int ITEMS_PER_STEP = 280;

  typedef struct packed {
    csvt_pkg::func_e func;
    logic [7:0]      character;
  } line_item_t;

  typedef struct packed {
    csvt_pkg::kind_e kind;
    logic [7:0]      data_byte;
  } token_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  csv_field_tokenizer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  line_item_t line_beats[$];
  token_t     pending_tokens[$];

  // Parser state as the block should hold it.
  csvt_pkg::mode_e parse_mode = csvt_pkg::MODE_UNQUOTED;
  logic [7:0]      active_delim = csvt_pkg::DELIM_RESET;
  // Delimiter used when composing lines.
  logic [7:0]      field_sep = csvt_pkg::DELIM_RESET;

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 65;
  bit          in_beat_taken = 1'b0;
  bit          cfg_beat_taken = 1'b0;
  int unsigned beats_queued = 0;
  int unsigned beats_accepted = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  int unsigned delim_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  function automatic bit next_token(input line_item_t beat, output token_t tok);
    tok.kind      = csvt_pkg::KIND_DATA;
    tok.data_byte = 8'h00;
    if (beat.func == csvt_pkg::FUNC_EOL) begin
      if (parse_mode == csvt_pkg::MODE_QUOTED) begin
        tok.kind = csvt_pkg::KIND_QUOTE_ERR;
      end else begin
        tok.kind = csvt_pkg::KIND_LINE_END;
      end
      parse_mode = csvt_pkg::MODE_UNQUOTED;
      return 1'b1;
    end
    if (parse_mode == csvt_pkg::MODE_QUOTED) begin
      if (beat.character == csvt_pkg::QUOTE_BYTE) begin
        parse_mode = csvt_pkg::MODE_PENDING;
        return 1'b0;
      end
      tok.data_byte = beat.character;
      return 1'b1;
    end
    if (parse_mode == csvt_pkg::MODE_PENDING && beat.character == csvt_pkg::QUOTE_BYTE) begin
      parse_mode    = csvt_pkg::MODE_QUOTED;
      tok.data_byte = csvt_pkg::QUOTE_BYTE;
      return 1'b1;
    end
    // Unquoted, or a pending quote that this byte has just closed.
    parse_mode = csvt_pkg::MODE_UNQUOTED;
    if (beat.character == csvt_pkg::QUOTE_BYTE) begin
      parse_mode = csvt_pkg::MODE_QUOTED;
      return 1'b0;
    end
    if (beat.character == active_delim) begin
      tok.kind = csvt_pkg::KIND_FIELD_END;
      return 1'b1;
    end
    tok.data_byte = beat.character;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Monitor: tracks configuration and input beats, checks output beats.
  always @(posedge clk_i) begin
    line_item_t beat;
    token_t     tok;
    token_t     want;
    in_beat_taken  = 1'b0;
    cfg_beat_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        active_delim   = cfg_data;
        cfg_beat_taken = 1'b1;
        delim_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat.func      = csvt_pkg::func_e'(s_axis_tuser);
        beat.character = s_axis_tdata;
        if (next_token(beat, tok)) pending_tokens = {pending_tokens, tok};
        in_beat_taken = 1'b1;
        beats_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        kind_seen[m_axis_tuser]++;
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    m_axis_tuser, m_axis_tdata));
        end else begin
          want = pending_tokens.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d",
                                      m_axis_tuser, want.kind));
          if (m_axis_tdata !== want.data_byte)
            report_mismatch($sformatf("data byte %02h, expected %02h",
                                      m_axis_tdata, want.data_byte));
        end
      end
      if (in_beat_taken || cfg_beat_taken || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Driver: one beat from the line queue whenever the previous one has gone.
  always @(negedge clk_i) begin
    line_item_t beat;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_beat_taken) begin
        if (line_beats.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          beat = line_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat.character;
          s_axis_tuser  <= beat.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    line_item_t beat;
    beat.func      = csvt_pkg::FUNC_BYTE;
    beat.character = b;
    line_beats = {line_beats, beat};
    beats_queued++;
  endtask

  task automatic push_eol();
    line_item_t beat;
    beat.func      = csvt_pkg::FUNC_EOL;
    beat.character = 8'($urandom_range(255, 0));
    line_beats = {line_beats, beat};
    beats_queued++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0));
    while (b == csvt_pkg::QUOTE_BYTE || b == field_sep);
    return b;
  endfunction

  // A line of fields; with broken set, one quoted field is left open.
  task automatic push_line(input bit broken);
    int n_fields;
    int open_field;
    n_fields   = $urandom_range(6, 1);
    open_field = broken ? $urandom_range(n_fields - 1, 0) : -1;
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) push_byte(field_sep);
      if ($urandom_range(1, 0) || f == open_field) begin
        push_byte(csvt_pkg::QUOTE_BYTE);
        repeat ($urandom_range(6, 0)) begin
          case ($urandom_range(6, 0))
            0: begin
              push_byte(csvt_pkg::QUOTE_BYTE);
              push_byte(csvt_pkg::QUOTE_BYTE);
            end
            1: push_byte(field_sep);
            default: push_byte(plain_byte());
          endcase
        end
        if (f != open_field) begin
          push_byte(csvt_pkg::QUOTE_BYTE);
          // Bytes after the closing quote land in the field unquoted.
          if ($urandom_range(4, 0) == 0) push_byte(plain_byte());
        end
      end else begin
        repeat ($urandom_range(6, 0)) push_byte(plain_byte());
      end
    end
    push_eol();
  endtask

  task automatic push_noise();
    int r;
    repeat ($urandom_range(12, 0)) begin
      r = $urandom_range(99, 0);
      if (r < 25) push_byte(csvt_pkg::QUOTE_BYTE);
      else if (r < 40) push_byte(field_sep);
      else push_byte(8'($urandom_range(255, 0)));
    end
    if ($urandom_range(4, 0) != 0) push_eol();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (beats_accepted != beats_queued || pending_tokens.size() != 0);
    // Beats that give no result may still sit in the pipeline.
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_delimiter(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk_i); while (!cfg_beat_taken);
    cfg_valid <= 1'b0;
    field_sep = value;
  endtask

  initial begin
    logic [7:0] delim_plan[6];
    int         r;
    int         target;
    delim_plan = '{8'h00, 8'hFF, csvt_pkg::QUOTE_BYTE, 8'h09, 8'h00,
                   csvt_pkg::DELIM_RESET};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines under the reset delimiter.
    push_byte(8'h00); push_byte(8'hFF); push_byte(csvt_pkg::DELIM_RESET); push_eol();
    // Delimiter inside quotes, doubled quote, then a quote closed by a byte.
    push_byte(csvt_pkg::QUOTE_BYTE); push_byte("a"); push_byte(csvt_pkg::DELIM_RESET);
    push_byte(csvt_pkg::QUOTE_BYTE); push_byte(csvt_pkg::QUOTE_BYTE);
    push_byte(csvt_pkg::QUOTE_BYTE); push_byte("b"); push_eol();
    // End of line inside quotes.
    push_byte(csvt_pkg::QUOTE_BYTE); push_eol();
    // End of line right after a closing quote.
    push_byte(csvt_pkg::QUOTE_BYTE); push_byte(csvt_pkg::QUOTE_BYTE); push_eol();
    // Delimiter right after a closing quote.
    push_byte(csvt_pkg::QUOTE_BYTE); push_byte("x"); push_byte(csvt_pkg::QUOTE_BYTE);
    push_byte(csvt_pkg::DELIM_RESET); push_eol();

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 4) delim_plan[p] = 8'($urandom_range(255, 0));
      write_delimiter(delim_plan[p]);
      target = beats_queued + ITEMS_PER_STEP;
      while (beats_queued < target) begin
        r = $urandom_range(99, 0);
        if (r < 70) push_line(1'b0);
        else if (r < 85) push_line(1'b1);
        else push_noise();
      end
      push_eol();
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d input beats under %0d delimiter writes and three idling profiles.",
             beats_accepted, delim_writes);
    $display("Results: %0d data, %0d field ends, %0d line ends, %0d open-quote errors.",
             kind_seen[csvt_pkg::KIND_DATA], kind_seen[csvt_pkg::KIND_FIELD_END],
             kind_seen[csvt_pkg::KIND_LINE_END], kind_seen[csvt_pkg::KIND_QUOTE_ERR]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
